// File: rtl/core/max_segment_tree_bin_allocator_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the segment tree bin allocator
// Clocked, reset-qualified property checks used by msta_back.
// ----------------------------------------------------------------------------
`ifndef MAX_SEGMENT_TREE_BIN_ALLOCATOR_UNIT_MACROS_SVH
`define MAX_SEGMENT_TREE_BIN_ALLOCATOR_UNIT_MACROS_SVH

// Checks prop at every rising edge of clk outside reset.
`define MSTA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks prop at every rising edge of clk, reset included.
`define MSTA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/core/msta_pkg.sv
// ----------------------------------------------------------------------------
// msta_pkg
// Types and codes shared by the segment tree bin allocator modules.
// ----------------------------------------------------------------------------
package msta_pkg;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOROOM = 2'd1;
  localparam logic [1:0] ST_BAD    = 2'd2;

  localparam logic [31:0] MAX_LEN_RESET = 32'd65536;

  typedef enum logic [3:0] {
    B_SWEEP,
    B_IDLE,
    B_DN_RD,
    B_DN_CMP,
    B_LF_RD,
    B_LF_CMP,
    B_UP_RD,
    B_UP_WR,
    B_FIN
  } back_state_t;

  // One classified item as it waits between the front and the back.
  typedef struct packed {
    logic        kind;
    logic [31:0] length;
    logic [9:0]  bin;
    logic        bad;
  } entry_t;

  typedef struct packed {
    logic sweeping;
  } back_status_t;

endpackage

// File: rtl/core/msta_ram.sv
// ----------------------------------------------------------------------------
// msta_ram
// Generic memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module msta_ram #(
  parameter int W = 32,
  parameter int D = 2047
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/msta_front.sv
// ----------------------------------------------------------------------------
// msta_front
// Accepts items, flags bad bins and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module msta_front
  import msta_pkg::*;
#(
  parameter int BINS = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic         in_kind,
  input  logic [31:0]  in_length,
  input  logic [9:0]   in_bin,
  input  back_status_t bstat,
  output logic         q_valid,
  output entry_t       q_head,
  input  logic         q_pop
);

  entry_t     q_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic       push, pop;
  entry_t     ent;

  always_comb begin
    ent.kind   = in_kind;
    ent.length = in_length;
    ent.bin    = in_bin;
    ent.bad    = (in_kind == KIND_FREE) && (32'(in_bin) >= 32'(BINS));
  end

  // No item is taken while the tree is being refilled.
  assign in_ready = (cnt_r != 2'd2) && !bstat.sweeping;
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && (cnt_r != 2'd0);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_head   = q_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= ent;
    end
  end

endmodule

// File: rtl/core/msta_back.sv
// ----------------------------------------------------------------------------
// msta_back
// Tree sequencer: walks the max-tree in memory and builds each result.
// ----------------------------------------------------------------------------
`include "max_segment_tree_bin_allocator_unit_macros.svh"

module msta_back
  import msta_pkg::*;
#(
  parameter int BINS = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [31:0]  cfg_wdata,
  input  logic         q_valid,
  input  entry_t       q_head,
  output logic         q_pop,
  output back_status_t bstat,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [1:0]   out_status,
  output logic [9:0]   out_chosen_bin,
  output logic [31:0]  out_largest_free
);

  localparam int NODES = 2 * BINS - 1;
  localparam int IW    = $clog2(NODES);
  localparam logic [IW-1:0] FL       = IW'(BINS - 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(NODES - 1);

  back_state_t state_r, state_nxt;
  logic [IW-1:0] k_r, k_nxt;
  logic [IW-1:0] sweep_r, sweep_nxt;
  logic [31:0]   v_r, v_nxt;
  logic [31:0]   len_r, len_nxt;
  logic          kind_r, kind_nxt;
  logic [31:0]   max_len_r, max_len_nxt;
  logic [31:0]   root_r, root_nxt;
  logic [1:0]    res_status_r, res_status_nxt;
  logic [9:0]    res_chosen_r, res_chosen_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_status_r, out_status_nxt;
  logic [9:0]    out_chosen_r, out_chosen_nxt;
  logic [31:0]   out_largest_r, out_largest_nxt;

  logic          we;
  logic [IW-1:0] waddr, raddr;
  logic [31:0]   wdata, rdata;

  logic [IW-1:0] left, desc_k, parent, sib, leaf_k, lf_idx;
  logic          go_left, desc_leaf, root_low, overflow, at_top, out_free;
  logic [32:0]   sum;
  logic [31:0]   max_v;

  msta_ram #(.W(32), .D(NODES)) u_tree (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign left      = {k_r[IW-2:0], 1'b1};
  assign go_left   = (rdata >= len_r);
  assign desc_k    = go_left ? left : left + IW'(1);
  assign desc_leaf = (desc_k >= FL);
  assign lf_idx    = desc_k - FL;
  assign parent    = (k_r - IW'(1)) >> 1;
  assign sib       = k_r[0] ? k_r + IW'(1) : k_r - IW'(1);
  assign at_top    = (parent == '0);
  assign leaf_k    = IW'(32'(q_head.bin)) + FL;
  assign root_low  = (root_r < q_head.length);
  assign sum       = {1'b0, rdata} + {1'b0, len_r};
  assign overflow  = (sum > {1'b0, max_len_r});
  assign max_v     = (v_r > rdata) ? v_r : rdata;
  assign out_free  = !out_valid_r || out_ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_SWEEP:  if (sweep_r == LAST_IDX) state_nxt = B_IDLE;
      B_IDLE: begin
        if (q_valid) begin
          if (q_head.bad) begin
            state_nxt = B_FIN;
          end else if (q_head.kind == KIND_ALLOC) begin
            state_nxt = root_low ? B_FIN : B_DN_RD;
          end else begin
            state_nxt = B_LF_RD;
          end
        end
      end
      B_DN_RD:  state_nxt = B_DN_CMP;
      B_DN_CMP: state_nxt = desc_leaf ? B_LF_RD : B_DN_RD;
      B_LF_RD:  state_nxt = B_LF_CMP;
      B_LF_CMP: state_nxt = (kind_r == KIND_FREE && overflow) ? B_FIN : B_UP_RD;
      B_UP_RD:  state_nxt = B_UP_WR;
      B_UP_WR:  state_nxt = at_top ? B_FIN : B_UP_RD;
      B_FIN:    if (out_free) state_nxt = B_IDLE;
      default:  state_nxt = B_SWEEP;
    endcase
    if (cfg_we) begin
      state_nxt = B_SWEEP;
    end
  end

  // Memory control and datapath.
  always_comb begin
    we              = 1'b0;
    waddr           = k_r;
    wdata           = max_len_r;
    raddr           = '0;
    q_pop           = 1'b0;
    k_nxt           = k_r;
    sweep_nxt       = sweep_r;
    v_nxt           = v_r;
    len_nxt         = len_r;
    kind_nxt        = kind_r;
    max_len_nxt     = max_len_r;
    root_nxt        = root_r;
    res_status_nxt  = res_status_r;
    res_chosen_nxt  = res_chosen_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_status_nxt  = out_status_r;
    out_chosen_nxt  = out_chosen_r;
    out_largest_nxt = out_largest_r;
    case (state_r)
      B_SWEEP: begin
        we        = 1'b1;
        waddr     = sweep_r;
        wdata     = max_len_r;
        sweep_nxt = sweep_r + IW'(1);
      end
      B_IDLE: begin
        if (q_valid) begin
          q_pop          = 1'b1;
          kind_nxt       = q_head.kind;
          len_nxt        = q_head.length;
          k_nxt          = (q_head.kind == KIND_FREE) ? leaf_k : '0;
          res_chosen_nxt = '0;
          if (q_head.bad) begin
            res_status_nxt = ST_BAD;
          end else if (q_head.kind == KIND_ALLOC && root_low) begin
            res_status_nxt = ST_NOROOM;
          end else begin
            res_status_nxt = ST_OK;
          end
        end
      end
      B_DN_RD:  raddr = left;
      B_DN_CMP: begin
        k_nxt = desc_k;
        if (desc_leaf) begin
          res_chosen_nxt = 10'(32'(lf_idx));
        end
      end
      B_LF_RD:  raddr = k_r;
      B_LF_CMP: begin
        if (kind_r == KIND_FREE && overflow) begin
          res_status_nxt = ST_BAD;
        end else begin
          we    = 1'b1;
          waddr = k_r;
          wdata = (kind_r == KIND_FREE) ? sum[31:0] : rdata - len_r;
          v_nxt = wdata;
        end
      end
      B_UP_RD:  raddr = sib;
      B_UP_WR: begin
        we    = 1'b1;
        waddr = parent;
        wdata = max_v;
        v_nxt = max_v;
        k_nxt = parent;
        if (at_top) begin
          root_nxt = max_v;
        end
      end
      B_FIN: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = res_status_r;
          out_chosen_nxt  = res_chosen_r;
          out_largest_nxt = root_r;
        end
      end
      default: begin
      end
    endcase
    if (cfg_we) begin
      max_len_nxt = cfg_wdata;
      root_nxt    = cfg_wdata;
      sweep_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_SWEEP;
      sweep_r     <= '0;
      max_len_r   <= MAX_LEN_RESET;
      root_r      <= MAX_LEN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      max_len_r   <= max_len_nxt;
      root_r      <= root_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r           <= k_nxt;
    v_r           <= v_nxt;
    len_r         <= len_nxt;
    kind_r        <= kind_nxt;
    res_status_r  <= res_status_nxt;
    res_chosen_r  <= res_chosen_nxt;
    out_status_r  <= out_status_nxt;
    out_chosen_r  <= out_chosen_nxt;
    out_largest_r <= out_largest_nxt;
  end

  assign bstat.sweeping   = (state_r == B_SWEEP);
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_chosen_bin   = out_chosen_r;
  assign out_largest_free = out_largest_r;

  `MSTA_ASSERT(a_no_pop_in_sweep, (state_r == B_SWEEP) |-> !q_pop, "pop during refill")
  `MSTA_ASSERT(a_root_bounded, root_r <= max_len_r, "root above bin capacity")
  `MSTA_ASSERT(a_desc_inner, (state_r == B_DN_RD) |-> (k_r < FL), "descent past the leaves")
  `MSTA_ASSERT(a_chosen_ok, (out_valid_r && out_status_r != ST_OK) |-> (out_chosen_r == '0),
               "bin reported on a failed item")

endmodule

// File: rtl/core/max_segment_tree_bin_allocator_unit.sv
// ----------------------------------------------------------------------------
// max_segment_tree_bin_allocator_unit
// First-fit bin allocator over a max-tree kept in one memory.
// ----------------------------------------------------------------------------
// Each item gives one result. An allocate walks from the root to a leaf and
// back up; a free goes to its leaf and back up. The tree memory serves one
// read per level on the way down and one on the way up. Reads are registered,
// so each level down takes a read state and a compare state, and each level
// up a read state and a write state; a refused or bad item goes straight to
// its result. The result is registered out of the final state and holds the
// sequencer while out_ready is low. A two-entry queue takes new items while
// the sequencer works. After reset and after each write of max_len all
// 2*BINS-1 nodes of the tree are refilled, one node a cycle, during which
// no item is accepted.
module max_segment_tree_bin_allocator_unit
  import msta_pkg::*;
#(
  parameter int BINS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [31:0] in_length,
  input  logic [9:0]  in_bin,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [9:0]  out_chosen_bin,
  output logic [31:0] out_largest_free
);

  back_status_t bstat;
  entry_t       q_head;
  logic         q_valid;
  logic         q_pop;

  msta_front #(.BINS(BINS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_kind   (in_kind),
    .in_length (in_length),
    .in_bin    (in_bin),
    .bstat     (bstat),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop)
  );

  msta_back #(.BINS(BINS)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .q_valid          (q_valid),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .bstat            (bstat),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_chosen_bin   (out_chosen_bin),
    .out_largest_free (out_largest_free)
  );

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for max_segment_tree_bin_allocator_unit
// Drives allocate and free items through the valid/ready channels, with
// random idle gaps on the sender and random stalls on the receiver. A
// scoreboard keeps its own copy of the max-tree, predicts each result and
// compares it field by field. The run walks through several bin capacities,
// the extremes among them.
// ----------------------------------------------------------------------------
module testbench;
  import msta_pkg::*;

  localparam int BINS  = 1024;
  localparam int NODES = 2 * BINS - 1;
  localparam int LEAF0 = BINS - 1;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  chosen_bin;
    logic [31:0] largest_free;
  } alloc_result_t;

  class alloc_scoreboard;
    logic [31:0]   node_max[NODES];
    logic [31:0]   capacity;
    alloc_result_t pending_results[$];
    int            errors;

    function new();
      errors = 0;
      refill(MAX_LEN_RESET);
    endfunction

    function void refill(logic [31:0] cap);
      capacity = cap;
      foreach (node_max[i]) node_max[i] = cap;
    endfunction

    function logic [31:0] leaf_value(int b);
      return node_max[LEAF0 + b];
    endfunction

    function logic [31:0] root_value();
      return node_max[0];
    endfunction

    function void fix_path(int k);
      while (k > 0) begin
        k = (k - 1) / 2;
        node_max[k] = (node_max[2*k+1] > node_max[2*k+2]) ? node_max[2*k+1]
                                                           : node_max[2*k+2];
      end
    endfunction

    // Applies one accepted item to the tree and queues the result it causes.
    function void note_item(logic kind, logic [31:0] len, logic [9:0] b);
      alloc_result_t r;
      int            k;
      logic [32:0]   sum;
      r = '0;
      r.status = ST_OK;
      if (kind == KIND_ALLOC) begin
        if (node_max[0] < len) begin
          r.status = ST_NOROOM;
        end else begin
          k = 0;
          while (k < LEAF0) k = (node_max[2*k+1] >= len) ? 2*k+1 : 2*k+2;
          r.chosen_bin = 10'(k - LEAF0);
          node_max[k] = node_max[k] - len;
          fix_path(k);
        end
      end else if (int'(b) >= BINS) begin
        r.status = ST_BAD;
      end else begin
        k = LEAF0 + int'(b);
        sum = {1'b0, node_max[k]} + {1'b0, len};
        if (sum > {1'b0, capacity}) begin
          r.status = ST_BAD;
        end else begin
          node_max[k] = sum[31:0];
          fix_path(k);
        end
      end
      r.largest_free = node_max[0];
      pending_results = {pending_results, r};
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [1:0] st, logic [9:0] ch, logic [31:0] lf);
      alloc_result_t w;
      if (pending_results.size() == 0) begin
        report("result arrived with no item pending");
      end else begin
        w = pending_results.pop_front();
        if (st !== w.status)
          report($sformatf("status %0d, predicted %0d", st, w.status));
        if (ch !== w.chosen_bin)
          report($sformatf("chosen_bin %0d, predicted %0d", ch, w.chosen_bin));
        if (lf !== w.largest_free)
          report($sformatf("largest_free %0d, predicted %0d", lf, w.largest_free));
      end
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [31:0] cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic        in_kind;
  logic [31:0] in_length;
  logic [9:0]  in_bin;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic [9:0]  out_chosen_bin;
  logic [31:0] out_largest_free;

  alloc_scoreboard sb = new();
  int  items_taken   = 0;
  int  results_taken = 0;
  bit  sender_idles  = 1;
  bit  receiver_stalls = 1;

  max_segment_tree_bin_allocator_unit #(.BINS(BINS)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_length        (in_length),
    .in_bin           (in_bin),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_chosen_bin   (out_chosen_bin),
    .out_largest_free (out_largest_free)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Outputs are sampled here, before the block's own updates of this edge land.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) sb.refill(cfg_wdata);
      if (in_valid && in_ready) begin
        sb.note_item(in_kind, in_length, in_bin);
        items_taken++;
      end
      if (out_valid && out_ready) begin
        sb.check_result(out_status, out_chosen_bin, out_largest_free);
        results_taken++;
      end
    end
  end

  task send_item(logic kind, logic [31:0] len, logic [9:0] b);
    int gap;
    int seen;
    gap = sender_idles ? $urandom_range(19, 0) : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  = 1'b1;
    in_kind   = kind;
    in_length = len;
    in_bin    = b;
    seen = items_taken;
    do @(negedge clk); while (items_taken == seen);
    in_valid = 1'b0;
  endtask

  task write_capacity(logic [31:0] cap);
    cfg_we    = 1'b1;
    cfg_wdata = cap;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task drain;
    while (sb.pending_results.size() > 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  // Random item shaped by the predicted tree, so that refusals, exact fits
  // and overflowing frees all turn up often.
  task send_random_item;
    logic [31:0] len;
    logic [31:0] room;
    logic [9:0]  b;
    b = 10'($urandom_range(BINS - 1, 0));
    if ($urandom_range(9, 0) < 6) begin
      case ($urandom_range(9, 0))
        0: len = 32'd0;
        1: len = sb.capacity;
        2: len = $urandom;
        3: len = sb.root_value();
        4: len = (sb.root_value() == 32'hFFFF_FFFF) ? 32'hFFFF_FFFF
                                                    : sb.root_value() + 1;
        default: len = $urandom_range(sb.capacity >> 2, 0);
      endcase
      send_item(KIND_ALLOC, len, b);
    end else begin
      room = sb.capacity - sb.leaf_value(b);
      case ($urandom_range(5, 0))
        0: len = room;
        1: len = (room == 32'hFFFF_FFFF) ? room : room + 1;
        2: len = $urandom;
        3: len = 32'd0;
        default: len = $urandom_range(room, 0);
      endcase
      send_item(KIND_FREE, len, b);
    end
  endtask

  // The receiver alone drives out_ready, from time zero on.
  initial begin
    forever begin
      int w;
      int seen;
      w = receiver_stalls ? $urandom_range(19, 0) : 0;
      if (w > 0) begin
        out_ready = 1'b0;
        repeat (w) @(negedge clk);
      end
      out_ready = 1'b1;
      seen = results_taken;
      do @(negedge clk); while (results_taken == seen);
    end
  end

  initial begin
    logic [31:0] caps[7];
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_kind   = KIND_ALLOC;
    in_length = '0;
    in_bin    = '0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // Directed opening at the reset capacity.
    send_item(KIND_ALLOC, 32'd0, 10'd0);
    send_item(KIND_ALLOC, 32'd65536, 10'd0);
    send_item(KIND_ALLOC, 32'd1, 10'd0);
    send_item(KIND_ALLOC, 32'd65537, 10'd0);
    send_item(KIND_ALLOC, 32'hFFFF_FFFF, 10'd0);
    send_item(KIND_FREE, 32'd65536, 10'd0);
    send_item(KIND_FREE, 32'd1, 10'd0);
    send_item(KIND_FREE, 32'd1, 10'd1023);
    send_item(KIND_FREE, 32'hFFFF_FFFF, 10'd512);
    send_item(KIND_FREE, 32'd0, 10'd5);
    send_item(KIND_ALLOC, 32'd65535, 10'd1023);
    send_item(KIND_ALLOC, 32'd65535, 10'd0);
    send_item(KIND_FREE, 32'd65535, 10'd1);
    send_item(KIND_FREE, 32'd65535, 10'd0);
    drain();

    write_capacity(32'hFFFF_FFFF);
    send_item(KIND_ALLOC, 32'hFFFF_FFFF, 10'd0);
    send_item(KIND_FREE, 32'hFFFF_FFFF, 10'd0);
    send_item(KIND_FREE, 32'd1, 10'd0);
    send_item(KIND_ALLOC, 32'hFFFF_FFFE, 10'd0);
    send_item(KIND_FREE, 32'hFFFF_FFFF, 10'd0);
    drain();

    caps = '{32'd65536, 32'd0, 32'd1, 32'd3, 32'hFFFF_FFFF, 32'd1000, $urandom};
    foreach (caps[p]) begin
      write_capacity(caps[p]);
      sender_idles    = (p % 3) != 1;
      receiver_stalls = (p % 3) != 2;
      repeat (170) send_random_item();
      drain();
    end

    if (sb.errors == 0)
      $display("** max_segment_tree_bin_allocator_unit: PASSED **");
    else
      $display("** max_segment_tree_bin_allocator_unit: FAILED **");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("** max_segment_tree_bin_allocator_unit: FAILED **");
    $finish;
  end

endmodule
